@@ rtl/wes_pkg.sv @@
// Shared types and constants for the wave equation stencil stepper.
package wes_pkg;

	localparam int DATA_W  = 32;
	localparam int IDX_W   = 12;
	localparam int CFG_IDX_W = 3;

	// item kinds
	localparam logic KIND_ADVANCE = 1'b0;
	localparam logic KIND_READ    = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DT_SQUARED  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_HX      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_HY      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LEFT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_RIGHT = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_CELL = 3'd7;

	// register reset values
	localparam logic [6:0]  RST_GRID_COLS   = 7'd64;
	localparam logic [6:0]  RST_GRID_ROWS   = 7'd64;
	localparam logic [29:0] RST_DT_SQUARED  = 30'd107374;
	localparam logic [31:0] RST_INV_HX      = 32'd16777216;
	localparam logic [31:0] RST_INV_HY      = 32'd16777216;
	localparam logic [29:0] RST_SPEED_LEFT  = 30'd10737418;
	localparam logic [29:0] RST_SPEED_RIGHT = 30'd42949673;
	localparam logic [11:0] RST_SOURCE_CELL = 12'd65;

	typedef struct packed {
		logic [6:0]  grid_cols;
		logic [6:0]  grid_rows;
		logic [29:0] dt_squared;
		logic [31:0] inv_two_hx_sq;
		logic [31:0] inv_two_hy_sq;
		logic [29:0] speed_left;
		logic [29:0] speed_right;
		logic [11:0] source_cell;
	} cfg_t;

	typedef struct packed {
		logic                     is_read;
		logic signed [DATA_W-1:0] amp;
		logic [IDX_W-1:0]         idx;
	} cmd_t;

endpackage

@@ rtl/wes_front.sv @@
// Input side: accepts items, classifies them and queues them for the sequencer.
module wes_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic signed [31:0]            source_amplitude,
	input  logic [11:0]                   cell_index,
	input  logic                          clearing,
	output logic                          cmd_valid,
	output wes_pkg::cmd_t                 cmd,
	input  logic                          cmd_pop
);

	wes_pkg::cmd_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	// hold off new items while full or while memory is cleared
	assign in_stall  = (count_q == 2'd2) || clearing;
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];

	// store the classified item
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q].is_read <= (kind == wes_pkg::KIND_READ);
			slot_q[wr_ptr_q].amp     <= source_amplitude;
			slot_q[wr_ptr_q].idx     <= cell_index;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (cmd_pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !cmd_pop) count_q <= count_q + 2'd1;
			else if (!push && cmd_pop) count_q <= count_q - 2'd1;
		end
	end

endmodule

@@ rtl/wes_mem.sv @@
// Two grid banks with two registered read ports each and one write port.
module wes_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic              clk,
	input  logic              sel,
	input  logic [AW-1:0]     rd_a,
	input  logic [AW-1:0]     rd_b,
	input  logic [AW-1:0]     rd_p,
	output logic signed [31:0] rdata_a,
	output logic signed [31:0] rdata_b,
	output logic signed [31:0] rdata_p,
	input  logic              wr_en,
	input  logic              wr_both,
	input  logic [AW-1:0]     wr_addr,
	input  logic signed [31:0] wr_data
);

	logic signed [31:0] mem0 [DEPTH];
	logic signed [31:0] mem1 [DEPTH];
	logic signed [31:0] q0_0, q0_1, q1_0, q1_1;
	logic sel_q;
	logic [AW-1:0] a0, a1;
	logic we0, we1;

	// the current bank serves ports a and b, the previous bank port p
	assign a0  = sel ? rd_p : rd_a;
	assign a1  = sel ? rd_a : rd_p;
	assign we0 = wr_en && (wr_both || sel);
	assign we1 = wr_en && (wr_both || !sel);

	always_ff @(posedge clk) begin
		if (we0) mem0[wr_addr] <= wr_data;
		q0_0 <= mem0[a0];
		q0_1 <= mem0[rd_b];
	end

	always_ff @(posedge clk) begin
		if (we1) mem1[wr_addr] <= wr_data;
		q1_0 <= mem1[a1];
		q1_1 <= mem1[rd_b];
	end

	always_ff @(posedge clk) begin
		sel_q <= sel;
	end

	assign rdata_a = sel_q ? q1_0 : q0_0;
	assign rdata_b = sel_q ? q1_1 : q0_1;
	assign rdata_p = sel_q ? q0_0 : q1_0;

endmodule

@@ rtl/wes_back.sv @@
// Sequencer: clears memory, walks the grid for a step and serves cell reads.
module wes_back #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64,
	parameter int CELLS    = 4096,
	parameter int AW       = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wes_pkg::cfg_t         cfg,
	input  logic                  cmd_valid,
	input  wes_pkg::cmd_t         cmd,
	output logic                  cmd_pop,
	output logic                  clearing,
	output logic                  bank_sel,
	output logic [AW-1:0]         rd_a,
	output logic [AW-1:0]         rd_b,
	output logic [AW-1:0]         rd_p,
	input  logic signed [31:0]    rdata_a,
	input  logic signed [31:0]    rdata_b,
	input  logic signed [31:0]    rdata_p,
	output logic                  wr_en,
	output logic                  wr_both,
	output logic [AW-1:0]         wr_addr,
	output logic signed [31:0]    wr_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [31:0]    cell_value
);

	localparam int CW = $clog2(MAX_COLS + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int IW = (AW > wes_pkg::IDX_W) ? AW : wes_pkg::IDX_W;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RDV, S_OUTW, S_CELL, S_RD1, S_RD2, S_RD3,
		S_DIFF, S_MUL1, S_SUM1, S_MUL2, S_SUM2, S_MUL3, S_FIN
	} state_t;

	state_t state_q;
	logic [RW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [AW-1:0] k_q;
	logic bank_q;
	logic inrange_q;
	logic signed [31:0] amp_q, val_q;
	logic signed [31:0] c_q, r_q, l_q, d_q, u_q, prev_q;
	logic signed [31:0] dr_q, dl_q, dd_q, du_q;
	logic signed [63:0] m_r_q, m_l_q, m_d_q, m_u_q;
	logic signed [31:0] fx0_q, fy0_q;
	logic signed [63:0] px_q, py_q, pa_q;
	logic signed [31:0] inner_q;

	logic [CW-1:0] cols, half;
	logic [RW-1:0] rows;
	logic [CW+RW-1:0] cells_used;
	logic [IW-1:0] idx_w, k_w, src_w;
	logic [AW-1:0] idx_addr, cols_a;
	logic [29:0] pc, pl;
	logic [30:0] two_pc, two_pl, sp_sum;
	logic border, last_cell, out_free, at_source;
	logic signed [31:0] fx1, fy1, src_term, nxt;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	// clamp dimensions into the supported range
	always_comb begin
		if (cfg.grid_cols < 7'd3) cols = CW'(3);
		else if (32'(cfg.grid_cols) > MAX_COLS) cols = CW'(MAX_COLS);
		else cols = CW'(cfg.grid_cols);
		if (cfg.grid_rows < 7'd3) rows = RW'(3);
		else if (32'(cfg.grid_rows) > MAX_ROWS) rows = RW'(MAX_ROWS);
		else rows = RW'(cfg.grid_rows);
	end

	assign half       = cols >> 1;
	assign cells_used = (CW+RW)'(cols) * (CW+RW)'(rows);
	assign idx_w      = IW'(cmd.idx);
	assign idx_addr   = idx_w[AW-1:0];
	assign k_w        = IW'(k_q);
	assign src_w      = IW'(cfg.source_cell);
	assign cols_a     = AW'(cols);
	assign border     = (i_q == '0) || (j_q == '0) || (i_q == rows - RW'(1))
		|| (j_q == cols - CW'(1));
	assign last_cell  = (i_q == rows - RW'(1)) && (j_q == cols - CW'(1));
	assign at_source  = (k_w == src_w);
	assign out_free   = !out_valid || !out_stall;

	// medium coefficients of this column and the one to its left
	assign pc     = (j_q < half) ? cfg.speed_left : cfg.speed_right;
	assign pl     = ((j_q - CW'(1)) < half) ? cfg.speed_left : cfg.speed_right;
	assign two_pc = {pc, 1'b0};
	assign two_pl = {pl, 1'b0};
	assign sp_sum = 31'(pc) + 31'(pl);

	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;
	assign clearing = (state_q == S_CLEAR);
	assign bank_sel = bank_q;

	// final combine of the cell update
	assign fx1      = sat32(px_q >>> 24);
	assign fy1      = sat32(py_q >>> 24);
	assign src_term = at_source ? amp_q : 32'sd0;
	assign nxt      = sat32((64'(c_q) <<< 1) - 64'(prev_q) + (pa_q >>> 30));

	// memory addresses and write strobes
	always_comb begin
		rd_a    = '0;
		rd_b    = '0;
		rd_p    = '0;
		wr_en   = 1'b0;
		wr_both = 1'b0;
		wr_addr = k_q;
		wr_data = 32'sd0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_both = 1'b1;
			end
			S_IDLE: rd_a = idx_addr;
			S_CELL: begin
				rd_a  = k_q;
				rd_b  = k_q + AW'(1);
				rd_p  = k_q;
				wr_en = border;
			end
			S_RD1: begin
				rd_a = k_q - AW'(1);
				rd_b = k_q + cols_a;
			end
			S_RD2: rd_a = k_q - cols_a;
			S_FIN: begin
				wr_en   = 1'b1;
				wr_data = nxt;
			end
			default: ;
		endcase
	end

	// sequencer state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			bank_q     <= 1'b0;
			out_valid  <= 1'b0;
			cell_value <= 32'sd0;
		end else begin
			if (out_valid && !out_stall && state_q != S_OUTW) out_valid <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					k_q <= k_q + AW'(1);
					if (k_q == AW'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						i_q <= '0;
						j_q <= '0;
						k_q <= '0;
						state_q <= cmd.is_read ? S_RDV : S_CELL;
					end
				end
				S_RDV: state_q <= S_OUTW;
				S_OUTW: begin
					if (out_free) begin
						out_valid  <= 1'b1;
						cell_value <= val_q;
						state_q    <= S_IDLE;
					end
				end
				S_CELL: begin
					if (border) begin
						k_q <= k_q + AW'(1);
						if (j_q == cols - CW'(1)) begin
							j_q <= '0;
							i_q <= i_q + RW'(1);
						end else begin
							j_q <= j_q + CW'(1);
						end
						if (last_cell) begin
							bank_q  <= ~bank_q;
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_RD1;
					end
				end
				S_RD1:  state_q <= S_RD2;
				S_RD2:  state_q <= S_RD3;
				S_RD3:  state_q <= S_DIFF;
				S_DIFF: state_q <= S_MUL1;
				S_MUL1: state_q <= S_SUM1;
				S_SUM1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_SUM2;
				S_SUM2: state_q <= S_MUL3;
				S_MUL3: state_q <= S_FIN;
				S_FIN: begin
					k_q     <= k_q + AW'(1);
					j_q     <= j_q + CW'(1);
					state_q <= S_CELL;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, one arithmetic step per state
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				amp_q     <= cmd.amp;
				inrange_q <= ((CW+RW > IW ? CW+RW : IW)'(cmd.idx)
					< (CW+RW > IW ? CW+RW : IW)'(cells_used));
			end
			S_RDV: val_q <= inrange_q ? rdata_a : 32'sd0;
			S_RD1: begin
				c_q    <= rdata_a;
				r_q    <= rdata_b;
				prev_q <= rdata_p;
			end
			S_RD2: begin
				l_q <= rdata_a;
				d_q <= rdata_b;
			end
			S_RD3: u_q <= rdata_a;
			S_DIFF: begin
				dr_q <= sat32(64'(r_q) - 64'(c_q));
				dl_q <= sat32(64'(l_q) - 64'(c_q));
				dd_q <= sat32(64'(d_q) - 64'(c_q));
				du_q <= sat32(64'(u_q) - 64'(c_q));
			end
			S_MUL1: begin
				m_r_q <= dr_q * $signed({1'b0, two_pc});
				m_l_q <= dl_q * $signed({1'b0, two_pl});
				m_d_q <= dd_q * $signed({1'b0, sp_sum});
				m_u_q <= du_q * $signed({1'b0, sp_sum});
			end
			S_SUM1: begin
				fx0_q <= sat32((m_r_q + m_l_q) >>> 30);
				fy0_q <= sat32((m_d_q + m_u_q) >>> 30);
			end
			S_MUL2: begin
				px_q <= fx0_q * $signed({1'b0, cfg.inv_two_hx_sq});
				py_q <= fy0_q * $signed({1'b0, cfg.inv_two_hy_sq});
			end
			S_SUM2: inner_q <= sat32(64'(src_term) + 64'(fx1) + 64'(fy1));
			S_MUL3: pa_q <= inner_q * $signed({1'b0, cfg.dt_squared});
			default: ;
		endcase
	end

	// no grid write while waiting for work
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !wr_en)
		else $error("grid written while idle");

	// banks swap only when a step finishes
	a_swap_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(bank_q != $past(bank_q)) |-> ($past(state_q) == S_CELL))
		else $error("bank swap outside step end");

	// a read result is loaded once the output register frees
	a_read_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUTW && out_free) |=> (out_valid && state_q == S_IDLE))
		else $error("read result not loaded");

	// no item is taken during the clearing pass
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !cmd_pop)
		else $error("item taken during clear");

endmodule

@@ rtl/wave_equation_stencil_step.sv @@
// Top level: 2D wave equation stepper over two fixed-point grid banks.
// Read item: popped from the queue, read via S_RDV and S_OUTW, then held until taken.
// Advance item: a border cell is zeroed in S_CELL alone, an interior cell walks the
// read, difference, multiply and sum states to S_FIN, one cell at a time.
// One item is worked on at a time; a two-entry queue decouples the input.
// Reset clears registers, then a clearing pass over all MAX_COLS*MAX_ROWS cells
// zeroes both banks while input is stalled; configuration writes still land.
module wave_equation_stencil_step #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  logic signed [31:0]  source_amplitude,
	input  logic [11:0]         cell_index,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  cell_value,
	input  logic                cfg_write,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(CELLS);

	wes_pkg::cfg_t cfg_q;
	wes_pkg::cmd_t cmd;
	logic cmd_valid, cmd_pop, clearing, bank_sel;
	logic [AW-1:0] rd_a, rd_b, rd_p, wr_addr;
	logic signed [31:0] rdata_a, rdata_b, rdata_p, wr_data;
	logic wr_en, wr_both;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_cols     <= wes_pkg::RST_GRID_COLS;
			cfg_q.grid_rows     <= wes_pkg::RST_GRID_ROWS;
			cfg_q.dt_squared    <= wes_pkg::RST_DT_SQUARED;
			cfg_q.inv_two_hx_sq <= wes_pkg::RST_INV_HX;
			cfg_q.inv_two_hy_sq <= wes_pkg::RST_INV_HY;
			cfg_q.speed_left    <= wes_pkg::RST_SPEED_LEFT;
			cfg_q.speed_right   <= wes_pkg::RST_SPEED_RIGHT;
			cfg_q.source_cell   <= wes_pkg::RST_SOURCE_CELL;
		end else if (cfg_write) begin
			unique case (cfg_index)
				wes_pkg::REG_GRID_COLS:   cfg_q.grid_cols     <= cfg_data[6:0];
				wes_pkg::REG_GRID_ROWS:   cfg_q.grid_rows     <= cfg_data[6:0];
				wes_pkg::REG_DT_SQUARED:  cfg_q.dt_squared    <= cfg_data[29:0];
				wes_pkg::REG_INV_HX:      cfg_q.inv_two_hx_sq <= cfg_data;
				wes_pkg::REG_INV_HY:      cfg_q.inv_two_hy_sq <= cfg_data;
				wes_pkg::REG_SPEED_LEFT:  cfg_q.speed_left    <= cfg_data[29:0];
				wes_pkg::REG_SPEED_RIGHT: cfg_q.speed_right   <= cfg_data[29:0];
				wes_pkg::REG_SOURCE_CELL: cfg_q.source_cell   <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	wes_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.kind             (kind),
		.source_amplitude (source_amplitude),
		.cell_index       (cell_index),
		.clearing         (clearing),
		.cmd_valid        (cmd_valid),
		.cmd              (cmd),
		.cmd_pop          (cmd_pop)
	);

	wes_mem #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.sel     (bank_sel),
		.rd_a    (rd_a),
		.rd_b    (rd_b),
		.rd_p    (rd_p),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b),
		.rdata_p (rdata_p),
		.wr_en   (wr_en),
		.wr_both (wr_both),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	wes_back #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS),
		.CELLS    (CELLS),
		.AW       (AW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.clearing   (clearing),
		.bank_sel   (bank_sel),
		.rd_a       (rd_a),
		.rd_b       (rd_b),
		.rd_p       (rd_p),
		.rdata_a    (rdata_a),
		.rdata_b    (rdata_b),
		.rdata_p    (rdata_p),
		.wr_en      (wr_en),
		.wr_both    (wr_both),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cell_value (cell_value)
	);

endmodule

@@ tb/wave_equation_stencil_step_check.sv @@
// Checker for the wave equation stepper: predicts read results and compares them.
`timescale 1ns / 100ps

module wave_equation_stencil_step_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               kind,
	input  logic signed [31:0] source_amplitude,
	input  logic [11:0]        cell_index,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] cell_value,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 pending,
	output int                 errors
);

	localparam int GRID_CELLS = 64 * 64;

	wes_pkg::cfg_t       regs;
	logic signed [31:0]  wave_cells [2][GRID_CELLS];
	logic                live_bank;
	logic signed [31:0]  expected_cells [$];

	function automatic longint sat_q824(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic int usable_dim(logic [6:0] v);
		if (v < 3) return 3;
		if (v > 64) return 64;
		return int'(v);
	endfunction

	// Advance every interior cell one time step, zero the border, swap banks.
	task automatic advance_wave(longint src);
		int cols, rows, i, j, k;
		longint c, pc, pl, dr, dl, dd, du, fx, fy, inner, acc;
		logic cb, nb;
		cols = usable_dim(regs.grid_cols);
		rows = usable_dim(regs.grid_rows);
		cb = live_bank;
		nb = !live_bank;
		for (i = 0; i < rows; i++) begin
			for (j = 0; j < cols; j++) begin
				k = i * cols + j;
				if (i == 0 || j == 0 || i == rows - 1 || j == cols - 1) begin
					wave_cells[nb][k] = '0;
					continue;
				end
				c  = longint'(wave_cells[cb][k]);
				pc = (j < cols / 2) ? longint'(regs.speed_left) : longint'(regs.speed_right);
				pl = (j - 1 < cols / 2) ? longint'(regs.speed_left) : longint'(regs.speed_right);
				dr = sat_q824(longint'(wave_cells[cb][k + 1]) - c);
				dl = sat_q824(longint'(wave_cells[cb][k - 1]) - c);
				dd = sat_q824(longint'(wave_cells[cb][k + cols]) - c);
				du = sat_q824(longint'(wave_cells[cb][k - cols]) - c);
				fx = sat_q824((dr * (2 * pc) + dl * (2 * pl)) >>> 30);
				fy = sat_q824((dd * (pl + pc) + du * (pl + pc)) >>> 30);
				fx = sat_q824((fx * longint'(regs.inv_two_hx_sq)) >>> 24);
				fy = sat_q824((fy * longint'(regs.inv_two_hy_sq)) >>> 24);
				inner = (k == int'(regs.source_cell)) ? src : 0;
				inner = sat_q824(inner + fx + fy);
				acc = (inner * longint'(regs.dt_squared)) >>> 30;
				wave_cells[nb][k] = 32'(sat_q824(2 * c - longint'(wave_cells[nb][k]) + acc));
			end
		end
		live_bank = nb;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic signed [31:0] want;
		int cols, rows;
		if (!arst_n) begin
			regs.grid_cols     <= wes_pkg::RST_GRID_COLS;
			regs.grid_rows     <= wes_pkg::RST_GRID_ROWS;
			regs.dt_squared    <= wes_pkg::RST_DT_SQUARED;
			regs.inv_two_hx_sq <= wes_pkg::RST_INV_HX;
			regs.inv_two_hy_sq <= wes_pkg::RST_INV_HY;
			regs.speed_left    <= wes_pkg::RST_SPEED_LEFT;
			regs.speed_right   <= wes_pkg::RST_SPEED_RIGHT;
			regs.source_cell   <= wes_pkg::RST_SOURCE_CELL;
			for (int n = 0; n < GRID_CELLS; n++) begin
				wave_cells[0][n] = '0;
				wave_cells[1][n] = '0;
			end
			live_bank = 1'b0;
			expected_cells.delete();
			pending <= 0;
			errors  <= 0;
		end else begin
			// track register writes
			if (cfg_write) begin
				case (cfg_index)
					wes_pkg::REG_GRID_COLS:   regs.grid_cols     <= cfg_data[6:0];
					wes_pkg::REG_GRID_ROWS:   regs.grid_rows     <= cfg_data[6:0];
					wes_pkg::REG_DT_SQUARED:  regs.dt_squared    <= cfg_data[29:0];
					wes_pkg::REG_INV_HX:      regs.inv_two_hx_sq <= cfg_data;
					wes_pkg::REG_INV_HY:      regs.inv_two_hy_sq <= cfg_data;
					wes_pkg::REG_SPEED_LEFT:  regs.speed_left    <= cfg_data[29:0];
					wes_pkg::REG_SPEED_RIGHT: regs.speed_right   <= cfg_data[29:0];
					wes_pkg::REG_SOURCE_CELL: regs.source_cell   <= cfg_data[11:0];
					default: ;
				endcase
			end
			// predict on each accepted item
			if (in_valid && !in_stall) begin
				if (kind == wes_pkg::KIND_ADVANCE) begin
					advance_wave(longint'(source_amplitude));
				end else begin
					cols = usable_dim(regs.grid_cols);
					rows = usable_dim(regs.grid_rows);
					want = (int'(cell_index) < cols * rows) ?
						wave_cells[live_bank][cell_index] : '0;
					expected_cells.push_back(want);
				end
			end
			// compare each accepted result with the oldest expectation
			if (out_valid && !out_stall) begin
				if (expected_cells.size() == 0) begin
					if (errors < 10)
						$display("mismatch: unexpected cell_value %0d", cell_value);
					errors <= errors + 1;
				end else begin
					want = expected_cells.pop_front();
					if (want !== cell_value) begin
						if (errors < 10)
							$display("mismatch: cell_value expected %0d got %0d",
								want, cell_value);
						errors <= errors + 1;
					end
				end
			end
			pending <= expected_cells.size();
		end
	end

endmodule

@@ tb/wave_equation_stencil_step_test.sv @@
// Top of the wave equation stepper testbench: stimulus, configuration and verdict.
`timescale 1ns / 100ps

module wave_equation_stencil_step_test;

	localparam int CYCLE_LIMIT = 2000000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               kind;
	logic signed [31:0] source_amplitude;
	logic [11:0]        cell_index;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] cell_value;
	logic               cfg_write;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	int                 pending;
	int                 errors;
	int                 cycles = 0;
	logic               calm;
	int                 cur_cols;
	int                 cur_rows;

	wave_equation_stencil_step i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .source_amplitude(source_amplitude), .cell_index(cell_index),
		.out_valid(out_valid), .out_stall(out_stall), .cell_value(cell_value),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	wave_equation_stencil_step_check i_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .source_amplitude(source_amplitude), .cell_index(cell_index),
		.out_valid(out_valid), .out_stall(out_stall), .cell_value(cell_value),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pending(pending), .errors(errors)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// stall results at random, never while calm
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 30);
	end

	// hard stop on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("wave_equation_stencil_step_test: done, errors");
			$finish;
		end
	end

	function automatic int usable(int v);
		return (v < 3) ? 3 : (v > 64) ? 64 : v;
	endfunction

	// Offer one item and hold it until accepted; called at a rising edge.
	task automatic send_item(logic k, logic signed [31:0] amp, logic [11:0] idx);
		logic stalled;
		if (!calm && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid         <= 1'b1;
		kind             <= k;
		source_amplitude <= amp;
		cell_index       <= idx;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
	endtask

	// Drain all reads, then let the advances still queued or in flight finish.
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (3 * 12 * cur_cols * cur_rows + 50) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic load_regs(int cols, int rows, logic [31:0] dt, logic [31:0] hx,
			logic [31:0] hy, logic [31:0] sl, logic [31:0] sr, logic [31:0] src);
		write_reg(wes_pkg::REG_GRID_COLS, cols);
		write_reg(wes_pkg::REG_GRID_ROWS, rows);
		write_reg(wes_pkg::REG_DT_SQUARED, dt);
		write_reg(wes_pkg::REG_INV_HX, hx);
		write_reg(wes_pkg::REG_INV_HY, hy);
		write_reg(wes_pkg::REG_SPEED_LEFT, sl);
		write_reg(wes_pkg::REG_SPEED_RIGHT, sr);
		write_reg(wes_pkg::REG_SOURCE_CELL, src);
		cfg_write <= 1'b0;
		cur_cols = usable(cols);
		cur_rows = usable(rows);
	endtask

	function automatic logic [31:0] pick_coef(logic [31:0] typical);
		case ($urandom_range(3))
			0: return '0;
			1: return $urandom;
			default: return typical + $urandom_range(0, typical);
		endcase
	endfunction

	initial begin
		int cols, rows, cells;
		logic signed [31:0] amp;
		calm             = 1'b0;
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		kind             = wes_pkg::KIND_ADVANCE;
		source_amplitude = '0;
		cell_index       = '0;
		cfg_write        = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		cur_cols         = 64;
		cur_rows         = 64;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full default grid: strongest source pulses at the default source cell
		send_item(wes_pkg::KIND_READ, '0, 12'd65);
		send_item(wes_pkg::KIND_ADVANCE, 32'sh7fffffff, '0);
		send_item(wes_pkg::KIND_READ, '0, 12'd65);
		send_item(wes_pkg::KIND_ADVANCE, 32'sh80000000, '0);
		send_item(wes_pkg::KIND_READ, '0, 12'd65);
		send_item(wes_pkg::KIND_READ, '0, 12'd66);
		send_item(wes_pkg::KIND_READ, '0, 12'd129);
		send_item(wes_pkg::KIND_READ, '0, 12'd0);
		send_item(wes_pkg::KIND_READ, '0, 12'd4095);
		settle();

		// clamped dimensions, every coefficient at its top, source on an interior cell
		load_regs(0, 127, 32'h3fffffff, 32'hffffffff, 32'hffffffff,
			32'h3fffffff, 32'h3fffffff, 32'd4);
		send_item(wes_pkg::KIND_ADVANCE, 32'sh7fffffff, '0);
		send_item(wes_pkg::KIND_ADVANCE, 32'sh80000000, '0);
		send_item(wes_pkg::KIND_ADVANCE, 32'sh7fffffff, '0);
		send_item(wes_pkg::KIND_READ, '0, 12'd4);
		send_item(wes_pkg::KIND_READ, '0, 12'd7);
		send_item(wes_pkg::KIND_READ, '0, 12'd191);
		send_item(wes_pkg::KIND_READ, '0, 12'd192);
		send_item(wes_pkg::KIND_READ, '0, 12'd4095);
		settle();
		load_regs(127, 2, '0, '0, '0, '0, '0, 32'd0);
		send_item(wes_pkg::KIND_ADVANCE, 32'sh7fffffff, '0);
		send_item(wes_pkg::KIND_READ, '0, 12'd65);
		send_item(wes_pkg::KIND_READ, '0, 12'd191);
		settle();

		// random phases, mostly on small grids, one of them with no idling on either side
		for (int p = 0; p < 8; p++) begin
			calm = (p == 3);
			cols = $urandom_range(3, 10);
			rows = $urandom_range(3, 10);
			if (p == 5) begin
				cols = $urandom_range(0, 2);
				rows = $urandom_range(65, 127);
			end
			cells = usable(cols) * usable(rows);
			load_regs(cols, rows, pick_coef(32'd107374) & 32'h3fffffff,
				pick_coef(32'd16777216), pick_coef(32'd16777216),
				pick_coef(32'd10737418) & 32'h3fffffff,
				pick_coef(32'd42949673) & 32'h3fffffff,
				($urandom_range(9) == 0) ? $urandom_range(0, 4095)
					: $urandom_range(0, cells - 1));
			for (int n = 0; n < 15; n++) begin
				if ($urandom_range(99) < 40) begin
					amp = $urandom;
					if ($urandom_range(1))
						amp = amp >>> $urandom_range(4, 12);
					send_item(wes_pkg::KIND_ADVANCE, amp, 12'($urandom));
				end else begin
					send_item(wes_pkg::KIND_READ, $urandom,
						($urandom_range(99) < 15) ? 12'($urandom)
						: 12'($urandom_range(0, cells + 2)));
				end
			end
			settle();
		end
		calm = 1'b0;

		if (errors == 0)
			$display("wave_equation_stencil_step_test: done, clean");
		else
			$display("wave_equation_stencil_step_test: done, errors");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/wes_pkg.sv
rtl/wes_front.sv
rtl/wes_mem.sv
rtl/wes_back.sv
rtl/wave_equation_stencil_step.sv
tb/wave_equation_stencil_step_check.sv
tb/wave_equation_stencil_step_test.sv
